FILE: rtl/fedx_pkg.sv
// ---------------------------------------------------------------------------
// fedx_pkg: shared definitions for the flag/escape deframer
// Byte codes, length limits, the result record and the output queue size.
// ---------------------------------------------------------------------------
package fedx_pkg;

  localparam logic [7:0] FLAG_BYTE = 8'h7e;
  localparam logic [7:0] ESC_BYTE  = 8'h7d;
  localparam logic [7:0] ESC_FLAG  = 8'h02;
  localparam logic [7:0] ESC_ESC   = 8'h01;

  localparam int RAW_W = 11;
  localparam logic [RAW_W-1:0] MAX_RAW_LENGTH = 11'd1024;
  localparam logic [RAW_W-1:0] MIN_RAW_RESET  = 11'd12;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SHORT    = 2'd1,
    ST_CHECKSUM = 2'd2,
    ST_LONG     = 2'd3
  } fedx_status_t;

  typedef struct packed {
    logic [7:0]   data_byte;
    logic         data_valid;
    logic         frame_end;
    fedx_status_t frame_status;
    logic         run_last;
  } fedx_result_t;

  function automatic fedx_result_t mk_data(input logic [7:0] b);
    fedx_result_t r;
    r              = '0;
    r.data_byte    = b;
    r.data_valid   = 1'b1;
    r.frame_status = ST_OK;
    return r;
  endfunction

  function automatic fedx_result_t mk_end(input fedx_status_t st);
    fedx_result_t r;
    r              = '0;
    r.frame_end    = 1'b1;
    r.frame_status = st;
    return r;
  endfunction

endpackage

FILE: rtl/flag_escape_deframer_xor_check.sv
// ---------------------------------------------------------------------------
// flag_escape_deframer_xor_check: byte-stuffed frame deframer
// Strips 0x7e flags, undoes 0x7d escapes, holds back the check byte and
// reports each frame's status (ok, too short, checksum mismatch, too long).
// ---------------------------------------------------------------------------
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+---------------------------------
//  in_      | input     | in_valid / in_ready  | in_wire_byte[7:0]
//  out_     | output    | out_valid / out_ready| out_data_byte, out_data_valid,
//           |           |                      | out_frame_end, out_frame_status,
//           |           |                      | out_run_last
//  cfg_     | input     | cfg_valid / cfg_ready| cfg_min_raw_length[10:0]
//
//  One wire byte is accepted per cycle unless the input is back-pressured.
//  An accepted byte is held in the input register, decoded in a single
//  pass, and its zero, one or two results enter a four-entry result queue
//  whose head is offered on the output port. The output port drains one
//  result a cycle while out_ready is high, so bytes that yield two results
//  can fill it; the held byte stalls whenever the queue holds more
//  than two entries. Reset (synchronous, active low) empties the pipeline
//  and queue, leaves the deframer idle and sets the minimum length to 12.
//  cfg_ready is always high.
//
module flag_escape_deframer_xor_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_wire_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_data_byte,
  output logic        out_data_valid,
  output logic        out_frame_end,
  output logic [1:0]  out_frame_status,
  output logic        out_run_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_min_raw_length
);
  import fedx_pkg::*;

  // configuration
  logic [RAW_W-1:0] min_len_r;

  // input register
  logic       s0_valid_r;
  logic [7:0] s0_byte_r;
  logic       s0_fire;

  // deframer state
  logic             in_frame_r, in_frame_nxt;
  logic             esc_r, esc_nxt;
  logic             hold_v_r, hold_v_nxt;
  logic [7:0]       hold_b_r, hold_b_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [RAW_W-1:0] cnt_r, cnt_nxt;

  // decode scratch
  logic             do_p1, do_p2;
  logic [7:0]       p1_byte, p2_byte;
  logic             is_close;
  logic [RAW_W-1:0] cnt_inc;
  fedx_status_t     status;
  logic [1:0]       n_res;
  fedx_result_t     res0, res1;

  // queue
  fedx_result_t   q_head;
  logic           q_not_empty;
  logic [QCW-1:0] q_fill;
  logic [1:0]     push_cnt;
  logic           q_pop;

  // ---- configuration port: always ready; the user must have it written only while idle, unchecked ----
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_RAW_RESET;
    end else if (cfg_valid) begin
      min_len_r <= cfg_min_raw_length;
    end
  end

  // ---- input register: advance when the queue has room for two results ----
  assign s0_fire  = s0_valid_r && (q_fill <= QCW'(QDEPTH - 2));
  assign in_ready = !s0_valid_r || s0_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ready) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s0_byte_r <= in_wire_byte;
    end
  end

  // ---- single-pass decode ----
  always_comb begin
    in_frame_nxt = in_frame_r;
    esc_nxt      = esc_r;
    hold_v_nxt   = hold_v_r;
    hold_b_nxt   = hold_b_r;
    xor_nxt      = xor_r;
    cnt_nxt      = cnt_r;
    do_p1        = 1'b0;
    do_p2        = 1'b0;
    p1_byte      = ESC_BYTE;
    p2_byte      = s0_byte_r;
    is_close     = 1'b0;
    status       = ST_OK;
    n_res        = 2'd0;
    res0         = '0;
    res1         = '0;
    cnt_inc      = (cnt_r < MAX_RAW_LENGTH) ? cnt_r + 11'd1 : cnt_r;

    if (!in_frame_r) begin
      // idle: only an opening flag matters, drop everything else
      if (s0_byte_r == FLAG_BYTE) begin
        in_frame_nxt = 1'b1;
        esc_nxt      = 1'b0;
        hold_v_nxt   = 1'b0;
        hold_b_nxt   = '0;
        xor_nxt      = '0;
        cnt_nxt      = 11'd1;
      end
    end else begin
      cnt_nxt = cnt_inc;
      if (s0_byte_r == FLAG_BYTE) begin
        // a dangling escape before the closing flag is literal
        is_close = 1'b1;
        do_p1    = esc_r;
        esc_nxt  = 1'b0;
      end else if (esc_r) begin
        esc_nxt = 1'b0;
        do_p1   = 1'b1;
        if (s0_byte_r == ESC_FLAG) begin
          p1_byte = FLAG_BYTE;
        end else if (s0_byte_r == ESC_ESC) begin
          p1_byte = ESC_BYTE;
        end else if (s0_byte_r == ESC_BYTE) begin
          esc_nxt = 1'b1;
        end else begin
          do_p2 = 1'b1;
        end
      end else if (s0_byte_r == ESC_BYTE) begin
        esc_nxt = 1'b1;
      end else begin
        do_p1   = 1'b1;
        p1_byte = s0_byte_r;
      end

      // push chain: each push releases the byte held back before it
      if (do_p1) begin
        if (hold_v_nxt) begin
          res0    = mk_data(hold_b_nxt);
          n_res   = 2'd1;
          xor_nxt = xor_nxt ^ hold_b_nxt;
        end
        hold_b_nxt = p1_byte;
        hold_v_nxt = 1'b1;
      end
      if (do_p2) begin
        // the first push always left a held byte
        if (n_res == 2'd0) begin
          res0 = mk_data(hold_b_nxt);
        end else begin
          res1 = mk_data(hold_b_nxt);
        end
        n_res      = n_res + 2'd1;
        xor_nxt    = xor_nxt ^ hold_b_nxt;
        hold_b_nxt = p2_byte;
        hold_v_nxt = 1'b1;
      end

      if (is_close) begin
        // priority: too short, then too long, then checksum
        if (cnt_inc < min_len_r) begin
          status = ST_SHORT;
        end else if (cnt_inc >= MAX_RAW_LENGTH) begin
          status = ST_LONG;
        end else if (!hold_v_nxt || (xor_nxt != hold_b_nxt)) begin
          status = ST_CHECKSUM;
        end else begin
          status = ST_OK;
        end
        if (n_res == 2'd0) begin
          res0 = mk_end(status);
        end else begin
          res1 = mk_end(status);
        end
        n_res        = n_res + 2'd1;
        in_frame_nxt = 1'b0;
        hold_v_nxt   = 1'b0;
        hold_b_nxt   = '0;
        xor_nxt      = '0;
        cnt_nxt      = '0;
      end
    end

    // mark the last result of this byte
    if (n_res == 2'd1) begin
      res0.run_last = 1'b1;
    end else if (n_res == 2'd2) begin
      res1.run_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      esc_r      <= 1'b0;
      hold_v_r   <= 1'b0;
      hold_b_r   <= '0;
      xor_r      <= '0;
      cnt_r      <= '0;
    end else if (s0_fire) begin
      in_frame_r <= in_frame_nxt;
      esc_r      <= esc_nxt;
      hold_v_r   <= hold_v_nxt;
      hold_b_r   <= hold_b_nxt;
      xor_r      <= xor_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  // ---- result queue and output port ----
  assign push_cnt = s0_fire ? n_res : 2'd0;
  assign q_pop    = q_not_empty && out_ready;

  fedx_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push_res0 (res0),
    .push_res1 (res1),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .fill      (q_fill)
  );

  assign out_valid        = q_not_empty;
  assign out_data_byte    = q_head.data_byte;
  assign out_data_valid   = q_head.data_valid;
  assign out_frame_end    = q_head.frame_end;
  assign out_frame_status = q_head.frame_status;
  assign out_run_last     = q_head.run_last;

  // ---- assertions ----
  a_q_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_fill <= QCW'(QDEPTH))
    else $error("result queue overfilled");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> (!esc_r && !hold_v_r && (cnt_r == '0)))
    else $error("idle deframer carries frame state");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_RAW_LENGTH)
    else $error("raw count beyond maximum");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_end) |-> (out_run_last && !out_data_valid))
    else $error("frame end not last result of its byte");

endmodule

FILE: rtl/fedx_outq.sv
// ---------------------------------------------------------------------------
// fedx_outq: result queue
// Small circular queue that takes up to two results a cycle and hands out one.
// ---------------------------------------------------------------------------
module fedx_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [1:0]           push_cnt,
  input  fedx_pkg::fedx_result_t push_res0,
  input  fedx_pkg::fedx_result_t push_res1,
  input  logic                 pop,
  output fedx_pkg::fedx_result_t head,
  output logic                 not_empty,
  output logic [fedx_pkg::QCW-1:0] fill
);
  import fedx_pkg::*;

  fedx_result_t   mem_r [QDEPTH];
  logic [QAW-1:0] wr_r, wr_nxt, wr1;
  logic [QAW-1:0] rd_r, rd_nxt;
  logic [QCW-1:0] count_r, count_nxt;

  assign wr1       = wr_r + 2'd1;
  assign wr_nxt    = wr_r + QAW'(push_cnt);
  assign rd_nxt    = rd_r + QAW'(pop);
  assign count_nxt = count_r + QCW'(push_cnt) - QCW'(pop);

  assign head      = mem_r[rd_r];
  assign not_empty = (count_r != '0);
  assign fill      = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  // payload slots carry no reset
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wr_r] <= push_res0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wr1] <= push_res1;
    end
  end

endmodule

FILE: dv/flag_escape_deframer_xor_check_tb.sv
// ---------------------------------------------------------------------------
// flag_escape_deframer_xor_check_tb: self-checking bench for the deframer
// Streams wire bytes into the deframer under random stalls on both channels.
// A tracker follows the flag, escape and hold-back rules on every accepted
// byte and checks each result transaction field by field. The minimum-length
// register is rewritten between phases, down to 2 and up to 1024.
// ---------------------------------------------------------------------------
module flag_escape_deframer_xor_check_tb;
  import fedx_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_LIMIT  = 10;
  localparam int LONG_BODY     = 1022; // guarantees the raw count saturates

  // Shapes of generated frames
  typedef enum int {
    FR_GOOD,       // stuffed body plus a correct check byte
    FR_BAD_CHECK,  // stuffed body plus a check byte with one bit flipped
    FR_LOOSE,      // unstuffed junk: bare escapes followed by anything
    FR_ESC_CLOSE   // body chosen so that a bare escape before the flag is the check
  } frame_kind_t;

  // -------------------------------------------------------------------------
  // Tracker: mirrors the deframer state and holds the results still owed
  // -------------------------------------------------------------------------
  class deframe_tracker;
    logic [10:0]  min_len;
    logic         in_frame;
    logic         esc_pending;
    logic         hold_valid;
    logic [7:0]   hold_byte;
    logic [7:0]   xor_sum;
    logic [10:0]  raw_count;
    fedx_result_t results_owed[$];
    fedx_result_t step_results[$];
    int           mismatches;

    function new();
      min_len     = MIN_RAW_RESET;
      in_frame    = 1'b0;
      esc_pending = 1'b0;
      hold_valid  = 1'b0;
      hold_byte   = '0;
      xor_sum     = '0;
      raw_count   = '0;
      mismatches  = 0;
    endfunction

    // Release the held byte (if any) and hold back the new one
    function void shift_in(logic [7:0] b);
      fedx_result_t r;
      if (hold_valid) begin
        r            = '0;
        r.data_byte  = hold_byte;
        r.data_valid = 1'b1;
        step_results = {step_results, r};
        xor_sum = xor_sum ^ hold_byte;
      end
      hold_byte  = b;
      hold_valid = 1'b1;
    endfunction

    function void take_plain(logic [7:0] b);
      if (b == ESC_BYTE)
        esc_pending = 1'b1;
      else
        shift_in(b);
    endfunction

    // Work out the results of one accepted wire byte
    function void take_wire_byte(logic [7:0] b);
      fedx_result_t r;
      fedx_status_t st;
      step_results.delete();
      if (!in_frame) begin
        if (b == FLAG_BYTE) begin
          in_frame    = 1'b1;
          esc_pending = 1'b0;
          hold_valid  = 1'b0;
          hold_byte   = '0;
          xor_sum     = '0;
          raw_count   = 11'd1;
        end
        return;
      end
      if (raw_count < MAX_RAW_LENGTH)
        raw_count = raw_count + 11'd1;
      if (b == FLAG_BYTE) begin
        if (esc_pending) begin
          esc_pending = 1'b0;
          shift_in(ESC_BYTE);
        end
        if (raw_count < min_len)
          st = ST_SHORT;
        else if (raw_count >= MAX_RAW_LENGTH)
          st = ST_LONG;
        else if (!hold_valid || xor_sum != hold_byte)
          st = ST_CHECKSUM;
        else
          st = ST_OK;
        r              = '0;
        r.frame_end    = 1'b1;
        r.frame_status = st;
        step_results   = {step_results, r};
        in_frame   = 1'b0;
        hold_valid = 1'b0;
        hold_byte  = '0;
        xor_sum    = '0;
        raw_count  = '0;
      end else if (esc_pending) begin
        esc_pending = 1'b0;
        if (b == ESC_FLAG)
          shift_in(FLAG_BYTE);
        else if (b == ESC_ESC)
          shift_in(ESC_BYTE);
        else begin
          shift_in(ESC_BYTE);
          take_plain(b);
        end
      end else begin
        take_plain(b);
      end
      if (step_results.size() > 0)
        step_results[step_results.size()-1].run_last = 1'b1;
      results_owed = {results_owed, step_results};
    endfunction

    function void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%s", msg);
    endfunction

    // Compare one result transaction with the oldest one owed
    function void match_result(logic [7:0] d, logic dv, logic fe, logic [1:0] fs, logic rl);
      fedx_result_t want;
      if (results_owed.size() == 0) begin
        note_mismatch($sformatf("unexpected result: data=%02h dv=%0b end=%0b st=%0d last=%0b",
                                d, dv, fe, fs, rl));
        return;
      end
      want = results_owed.pop_front();
      if (d !== want.data_byte || dv !== want.data_valid || fe !== want.frame_end ||
          fs !== want.frame_status || rl !== want.run_last)
        note_mismatch($sformatf({"result mismatch: expected data=%02h dv=%0b end=%0b st=%0d",
                                 " last=%0b, got data=%02h dv=%0b end=%0b st=%0d last=%0b"},
                                want.data_byte, want.data_valid, want.frame_end,
                                want.frame_status, want.run_last, d, dv, fe, fs, rl));
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Clock, reset and block signals; every input starts at a known value
  // -------------------------------------------------------------------------
  logic        clk;
  logic        rst_n              = 1'b0;
  logic        in_valid           = 1'b0;
  logic        in_ready;
  logic [7:0]  in_wire_byte       = '0;
  logic        out_valid;
  logic        out_ready          = 1'b0;
  logic [7:0]  out_data_byte;
  logic        out_data_valid;
  logic        out_frame_end;
  logic [1:0]  out_frame_status;
  logic        out_run_last;
  logic        cfg_valid          = 1'b0;
  logic        cfg_ready;
  logic [10:0] cfg_min_raw_length = '0;

  deframe_tracker tracker;
  int unsigned    cycle_count  = 0;
  int             framed_bytes = 0;  // bytes that the deframer does not simply drop
  int             gap_odds     = 0;  // sender idles before one byte in this many; 0 = never
  bit             idle_on      = 1'b1;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  flag_escape_deframer_xor_check i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_wire_byte       (in_wire_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_data_byte      (out_data_byte),
    .out_data_valid     (out_data_valid),
    .out_frame_end      (out_frame_end),
    .out_frame_status   (out_frame_status),
    .out_run_last       (out_run_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_min_raw_length (cfg_min_raw_length)
  );

  // Watchdog: abandon the run if it hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result monitor: the values read here are those from before the edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.match_result(out_data_byte, out_data_valid, out_frame_end,
                           out_frame_status, out_run_last);
  end

  // Receiver: stall in random bursts, with calm stretches, some of them long,
  // in between; once idling is switched off, hold ready high
  initial begin
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 7) == 0)
          repeat ($urandom_range(40, 120)) @(posedge clk);
        else
          repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Sender tasks
  // -------------------------------------------------------------------------

  // Offer one byte and hold it until the transaction completes. Valid is not
  // dropped between back-to-back bytes, only before an idle burst.
  task automatic send_byte(input logic [7:0] b);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_wire_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (tracker.in_frame || b == FLAG_BYTE)
      framed_bytes++;
    tracker.take_wire_byte(b);
  endtask

  // Drop valid, wait for every owed result, then let the pipeline settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.results_owed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Rewrite the minimum length only once the block has gone quiet
  task automatic write_min_length(input logic [10:0] value);
    wait_drained();
    cfg_valid          <= 1'b1;
    cfg_min_raw_length <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tracker.min_len = value;
  endtask

  // Payload bytes lean towards the flag, the escape and the escape codes
  function automatic logic [7:0] pick_payload();
    int roll;
    roll = $urandom_range(0, 15);
    case (roll)
      0, 1, 2: pick_payload = FLAG_BYTE;
      3, 4, 5: pick_payload = ESC_BYTE;
      6:       pick_payload = ESC_FLAG;
      7:       pick_payload = ESC_ESC;
      8:       pick_payload = 8'h00;
      9:       pick_payload = 8'hff;
      default: pick_payload = 8'($urandom);
    endcase
  endfunction

  // Build one frame of the given shape and send it, flags included
  task automatic send_frame(input int body_len, input frame_kind_t kind);
    logic [7:0] body[$];
    logic [7:0] chk;
    logic [7:0] b;
    chk = '0;
    for (int i = 0; i < body_len; i++) begin
      b = pick_payload();
      if (kind == FR_LOOSE && b == FLAG_BYTE)
        b = ESC_BYTE;
      body = {body, b};
      chk = chk ^ b;
    end
    case (kind)
      FR_GOOD:      body = {body, chk};
      FR_BAD_CHECK: body = {body, 8'(chk ^ (8'd1 << $urandom_range(0, 7)))};
      // steer the sum so that the trailing bare escape is the right check
      FR_ESC_CLOSE: body = {body, 8'(chk ^ ESC_BYTE)};
      default:      ;
    endcase
    send_byte(FLAG_BYTE);
    foreach (body[i]) begin
      if (kind == FR_LOOSE)
        send_byte(body[i]);
      else if (body[i] == FLAG_BYTE) begin
        send_byte(ESC_BYTE);
        send_byte(ESC_FLAG);
      end else if (body[i] == ESC_BYTE) begin
        send_byte(ESC_BYTE);
        send_byte(ESC_ESC);
      end else
        send_byte(body[i]);
    end
    if (kind == FR_ESC_CLOSE)
      send_byte(ESC_BYTE);
    send_byte(FLAG_BYTE);
  endtask

  // Mostly well-formed frames with random content; the rest is line noise
  // between frames, corrupted checks, loose escapes, empty frames and pauses to drain
  task automatic run_phase(input int budget);
    int goal;
    int roll;
    int len;
    logic [7:0] junk;
    goal = framed_bytes + budget;
    while (framed_bytes < goal) begin
      gap_odds = (!idle_on || $urandom_range(0, 2) == 0) ? 0 : 4;
      roll     = $urandom_range(0, 19);
      len      = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 16);
      if (roll == 0) begin
        repeat ($urandom_range(1, 4)) begin
          junk = 8'($urandom);
          if (junk == FLAG_BYTE)
            junk = 8'h00;
          send_byte(junk);
        end
      end else if (roll == 1)
        wait_drained();
      else if (roll < 12)
        send_frame(len, FR_GOOD);
      else if (roll < 14)
        send_frame(len, FR_BAD_CHECK);
      else if (roll < 17)
        send_frame(len, FR_LOOSE);
      else if (roll < 19)
        send_frame(len, FR_ESC_CLOSE);
      else
        send_frame(0, FR_LOOSE);
    end
    wait_drained();
  endtask

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin
    logic [7:0] directed_bytes[];
    directed_bytes = '{
      8'hff,                          // dropped while idle
      FLAG_BYTE,                      // open
      ESC_BYTE, ESC_FLAG,             // stands for a flag
      ESC_BYTE, ESC_ESC,              // stands for an escape
      ESC_BYTE, 8'h05,                // literal escape, then a plain byte
      ESC_BYTE, ESC_BYTE, ESC_ESC,    // literal escape, then a fresh escape pair
      ESC_BYTE, FLAG_BYTE,            // escape right before the closing flag
      FLAG_BYTE, FLAG_BYTE,           // empty frame, nothing to check against
      FLAG_BYTE, 8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04, 8'h02, 8'h01,
      8'hff, FLAG_BYTE                // correct check, one byte short of the minimum
    };
    tracker = new();

    // Hold reset low at the start, once only
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed bytes at the reset minimum length
    gap_odds = 3;
    foreach (directed_bytes[i])
      send_byte(directed_bytes[i]);
    wait_drained();

    // Smallest minimum: empty frames become checksum failures; then one
    // unstuffed frame long enough to saturate the raw count
    write_min_length(11'd2);
    run_phase(130);
    gap_odds = 4;
    send_frame(LONG_BODY, FR_LOOSE);
    wait_drained();

    // Largest minimum: only too short or too long can come out
    write_min_length(11'd1024);
    run_phase(70);

    // Random minimums around the usual frame sizes
    write_min_length(11'($urandom_range(3, 30)));
    run_phase(120);
    write_min_length(11'($urandom_range(3, 30)));
    run_phase(120);

    // Last part at full rate on both sides
    idle_on  = 1'b0;
    gap_odds = 0;
    write_min_length(MIN_RAW_RESET);
    run_phase(100);

    if (tracker.mismatches == 0 && tracker.results_owed.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
